@@ design/crps_pkg.sv @@
// ----------------------------------------------------------------------------
// crps_pkg - shared types and helpers for the card row pixel shader
// Register indexes, RGB565 type, divide-by-255 and corner inset function.
// ----------------------------------------------------------------------------
package crps_pkg;

    // Corner circle radius in pixels
    localparam int ARC_RADIUS_PX = 4;

    // Width of the clamped edge distance (up to RADIUS+1) and of the inset (up to RADIUS)
    localparam int CW = $clog2(ARC_RADIUS_PX + 2);

    typedef logic [15:0] t_rgb565;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DIGIT_COLOR = 3'd0,
        CFG_CARD_TOP    = 3'd1,
        CFG_CARD_BOTTOM = 3'd2,
        CFG_CARD_WIDTH  = 3'd3,
        CFG_CARD_HEIGHT = 3'd4
    } t_cfg_idx;

    // Exact x/255 for x up to 63*255, by shift-add reciprocal
    function automatic logic [5:0] div255(input logic [13:0] x);
        logic [14:0] t;
        t = {1'b0, x} + {9'd0, x[13:8]} + 15'd1;
        return t[13:8];
    endfunction

    // Inset in columns for a row at distance dy from the rounded edge
    // (dy = 0 means the row is clear of both corner bands)
    function automatic logic [CW-1:0] arc_inset(input logic [CW-1:0] dy);
        int  ins;
        int  ex;
        int  ey;
        logic done;
        ins  = 0;
        done = (dy == '0);
        ey   = 2 * int'(dy) - 1;
        for (int k = 0; k < ARC_RADIUS_PX; k++) begin
            ex = 2 * (ARC_RADIUS_PX - k) - 1;
            if (!done) begin
                if (ex * ex + ey * ey <= 4 * ARC_RADIUS_PX * ARC_RADIUS_PX) begin
                    done = 1'b1;
                end else begin
                    ins = ins + 1;
                end
            end
        end
        return CW'(ins);
    endfunction

endpackage

@@ design/crps_blend.sv @@
// ----------------------------------------------------------------------------
// crps_blend - two-stage RGB565 alpha blend
// Each channel becomes (bg*(255-a) + fg*a)/255, truncated. Stage one forms
// the weighted sums, stage two divides by 255 and repacks.
// ----------------------------------------------------------------------------
module crps_blend
    import crps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_rgb565     i_bg,
    input  t_rgb565     i_fg,
    input  logic [7:0]  i_alpha,
    output logic        o_valid,
    output t_rgb565     o_px
);

    logic [7:0]  n_inv;
    logic [12:0] n_sum_r;
    logic [13:0] n_sum_g;
    logic [12:0] n_sum_b;
    logic        r_valid1;
    logic [12:0] r_sum_r;
    logic [13:0] r_sum_g;
    logic [12:0] r_sum_b;
    logic [5:0]  q_r;
    logic [5:0]  q_g;
    logic [5:0]  q_b;

    // Weighted channel sums
    assign n_inv   = 8'd255 - i_alpha;
    assign n_sum_r = {8'd0, i_bg[15:11]} * {5'd0, n_inv}
                   + {8'd0, i_fg[15:11]} * {5'd0, i_alpha};
    assign n_sum_g = {8'd0, i_bg[10:5]} * {6'd0, n_inv}
                   + {8'd0, i_fg[10:5]} * {6'd0, i_alpha};
    assign n_sum_b = {8'd0, i_bg[4:0]} * {5'd0, n_inv}
                   + {8'd0, i_fg[4:0]} * {5'd0, i_alpha};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_r <= n_sum_r;
        r_sum_g <= n_sum_g;
        r_sum_b <= n_sum_b;
    end

    // Divide by 255 and repack
    assign q_r = div255({1'b0, r_sum_r});
    assign q_g = div255(r_sum_g);
    assign q_b = div255({1'b0, r_sum_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_px <= {q_r[4:0], q_g, q_b[4:0]};
    end

endmodule

@@ design/card_row_pixel_shader_top.sv @@
// ----------------------------------------------------------------------------
// card_row_pixel_shader_top - pixel shader for a rounded flip-clock card
// Picks the card half colour, blends the digit over it, darkens by shade
// and clears the write flag and pixel inside the rounded corners and off the card.
//
//   channel   handshake                  payload
//   -------   ------------------------   ----------------------------------
//   item in   start / busy               card_row, column, glyph_alpha,
//                                        is_blank, shade
//   result    o_strobe (one cycle)       o_pixel, o_write_enable
//   config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per clock; busy stays low. Each result passes through decode, two
// blend stages and two shade stages. Synchronous active-low reset clears the
// pipeline valid bits and loads the register defaults. The receiver cannot
// stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module card_row_pixel_shader_top
    import crps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_card_row,
    input  logic [7:0]  i_column,
    input  logic [7:0]  i_glyph_alpha,
    input  logic        i_is_blank,
    input  logic [7:0]  i_shade,
    output logic        o_strobe,
    output logic [15:0] o_pixel,
    output logic        o_write_enable,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_rgb565     r_digit_color;
    t_rgb565     r_card_top_color;
    t_rgb565     r_card_bottom_color;
    logic [7:0]  r_card_width;
    logic [7:0]  r_card_height;

    logic        accept;
    logic [9:0]  row_ext;
    logic [9:0]  h_ext;
    logic        row_low;
    logic        row_high;
    logic [9:0]  dy_low;
    logic [9:0]  dy_high;
    logic [9:0]  dy_sel;
    logic [CW-1:0] n_dy;
    logic        n_in_bounds;
    t_rgb565     n_base;
    logic [7:0]  n_alpha;

    logic        r1_valid;
    logic [CW-1:0] r1_dy;
    logic        r1_in_bounds;
    logic [7:0]  r1_col;
    t_rgb565     r1_base;
    logic [7:0]  r1_alpha;
    logic [7:0]  r1_shade;

    logic [CW-1:0] inset;
    logic        n_we;
    logic        r2_we;
    logic [7:0]  r2_shade;
    logic        r3_we;
    logic [7:0]  r3_shade;
    logic        r4_we;
    logic        r5_we;

    logic        mix_valid;
    t_rgb565     mix_px;
    t_rgb565     shade_fg;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_color       <= 16'hFFFF;
            r_card_top_color    <= 16'h0000;
            r_card_bottom_color <= 16'h0000;
            r_card_width        <= 8'd64;
            r_card_height       <= 8'd96;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DIGIT_COLOR: r_digit_color       <= i_cfg_data;
                CFG_CARD_TOP:    r_card_top_color    <= i_cfg_data;
                CFG_CARD_BOTTOM: r_card_bottom_color <= i_cfg_data;
                CFG_CARD_WIDTH:  r_card_width        <= i_cfg_data[7:0];
                CFG_CARD_HEIGHT: r_card_height       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Decode: distance into the top or bottom corner band, bounds, base colour
    assign row_ext  = {2'd0, i_card_row};
    assign h_ext    = {2'd0, r_card_height};
    assign row_low  = row_ext < 10'(ARC_RADIUS_PX);
    assign row_high = (row_ext + 10'(ARC_RADIUS_PX)) >= h_ext;
    assign dy_low   = 10'(ARC_RADIUS_PX) - row_ext;
    assign dy_high  = row_ext + 10'(ARC_RADIUS_PX + 1) - h_ext;

    always_comb begin
        if (row_low) begin
            dy_sel = dy_low;
        end else if (row_high) begin
            dy_sel = dy_high;
        end else begin
            dy_sel = 10'd0;
        end
        // beyond one past the radius every row gets the full inset
        if (dy_sel > 10'(ARC_RADIUS_PX + 1)) begin
            n_dy = CW'(ARC_RADIUS_PX + 1);
        end else begin
            n_dy = dy_sel[CW-1:0];
        end
    end

    assign n_in_bounds = (i_card_row < r_card_height) && (i_column < r_card_width);
    assign n_base      = (i_card_row < {1'b0, r_card_height[7:1]}) ?
                         r_card_top_color : r_card_bottom_color;
    // a blank card blends with zero coverage, which leaves the base as is
    assign n_alpha     = i_is_blank ? 8'd0 : i_glyph_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dy        <= n_dy;
        r1_in_bounds <= n_in_bounds;
        r1_col       <= i_column;
        r1_base      <= n_base;
        r1_alpha     <= n_alpha;
        r1_shade     <= i_shade;
    end

    // Digit over card colour
    crps_blend u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_valid),
        .i_bg    (r1_base),
        .i_fg    (r_digit_color),
        .i_alpha (r1_alpha),
        .o_valid (mix_valid),
        .o_px    (mix_px)
    );

    // Corner test alongside the first blend stage
    assign inset = arc_inset(r1_dy);
    assign n_we  = r1_in_bounds
                && ({1'b0, r1_col} >= 9'(inset))
                && (({1'b0, r1_col} + 9'(inset)) < {1'b0, r_card_width});

    always_ff @(posedge i_clk) begin
        r2_we    <= n_we;
        r2_shade <= r1_shade;
        r3_we    <= r2_we;
        r3_shade <= r2_shade;
        r4_we    <= r3_we;
        r5_we    <= r4_we;
    end

    // Shade toward black; a masked pixel goes in as black and stays zero.
    // Full shade scales by 255/255, which leaves the colour as is.
    assign shade_fg = r3_we ? mix_px : 16'h0000;

    crps_blend u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .i_bg    (16'h0000),
        .i_fg    (shade_fg),
        .i_alpha (r3_shade),
        .o_valid (o_strobe),
        .o_px    (o_pixel)
    );

    assign o_write_enable = r5_we;

endmodule

@@ design/crps_checker.sv @@
// ----------------------------------------------------------------------------
// crps_checker - port-level checks for the card row pixel shader
// Watches latency, one result per item, the masked pixel value and busy.
// ----------------------------------------------------------------------------
module crps_checker
    import crps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        o_strobe,
    input  logic [15:0] o_pixel,
    input  logic        o_write_enable
);

    // Every taken item yields its result after the decode, blend and shade stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("item taken without a result five cycles later");

    // No result without a taken item that entered the pipeline for it
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("result without a matching item");

    // Corner or out-of-card pixels come out black
    a_masked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_write_enable) |-> (o_pixel == 16'h0000))
        else $error("masked pixel is not zero");

    // The shader is never busy, so it can take an item in every cycle
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("shader reported busy");

endmodule

bind card_row_pixel_shader_top crps_checker u_crps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_pixel        (o_pixel),
    .o_write_enable (o_write_enable)
);

@@ tb/card_row_pixel_shader_top_test.sv @@
// ----------------------------------------------------------------------------
// card_row_pixel_shader_top_test - self-checking bench for the card shader
// Feeds pixel items and register writes from one queue, predicts every
// shaded pixel and write flag, and compares each strobed result in order.
// ----------------------------------------------------------------------------
module card_row_pixel_shader_top_test
    import crps_pkg::*;
();

    typedef enum {
        STEP_PIXEL,
        STEP_REG_WRITE,
        STEP_GAP,
        STEP_SETTLE
    } t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [7:0]  alpha;
        logic        blank;
        logic [7:0]  shade;
        logic [2:0]  reg_idx;
        logic [15:0] reg_data;
        int          gap_cycles;
    } t_step;

    typedef struct {
        t_rgb565 pixel;
        logic    we;
    } t_shaded;

    // Highest code the index port can carry; codes above CFG_CARD_HEIGHT are unused
    localparam logic [2:0] CFG_IDX_MAX = '1;
    localparam int LAST_PHASE = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  i_card_row = '0;
    logic [7:0]  i_column = '0;
    logic [7:0]  i_glyph_alpha = '0;
    logic        i_is_blank = 1'b0;
    logic [7:0]  i_shade = '0;
    logic        o_strobe;
    logic [15:0] o_pixel;
    logic        o_write_enable;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    t_step   step_q[$];
    t_shaded pixel_due_q[$];

    // Shadow copy of the shader registers
    t_rgb565    digit_rgb;
    t_rgb565    card_top_rgb;
    t_rgb565    card_bot_rgb;
    logic [7:0] card_w;
    logic [7:0] card_h;

    int      items_taken = 0;
    int      results_seen = 0;
    int      mismatches = 0;
    int      idle_left = 0;
    logic    nxt_start;
    logic    nxt_cfg;
    t_step   head;
    t_shaded due;
    t_shaded want;

    card_row_pixel_shader_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_card_row     (i_card_row),
        .i_column       (i_column),
        .i_glyph_alpha  (i_glyph_alpha),
        .i_is_blank     (i_is_blank),
        .i_shade        (i_shade),
        .o_strobe       (o_strobe),
        .o_pixel        (o_pixel),
        .o_write_enable (o_write_enable),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Per-channel RGB565 mix: (bg*(255-a) + fg*a)/255, truncated
    function automatic t_rgb565 blend565(input t_rgb565 bg, input t_rgb565 fg,
                                         input logic [7:0] a);
        int na;
        int r;
        int g;
        int b;
        na = 255 - int'(a);
        r  = (int'(bg[15:11]) * na + int'(fg[15:11]) * int'(a)) / 255;
        g  = (int'(bg[10:5]) * na + int'(fg[10:5]) * int'(a)) / 255;
        b  = (int'(bg[4:0]) * na + int'(fg[4:0]) * int'(a)) / 255;
        return {5'(r), 6'(g), 5'(b)};
    endfunction

    // Predict one shaded pixel from the shadow registers
    function automatic t_shaded shade_pixel(input logic [7:0] row, input logic [7:0] col,
                                            input logic [7:0] alpha, input logic blank,
                                            input logic [7:0] shade);
        t_shaded res;
        t_rgb565 px;
        int      rad;
        int      h;
        int      w;
        int      dy;
        int      inset;
        int      ex;
        int      ey;
        rad   = ARC_RADIUS_PX;
        h     = int'(card_h);
        w     = int'(card_w);
        dy    = 0;
        inset = 0;
        // distance into the top or bottom corner band
        if (int'(row) < rad) begin
            dy = rad - int'(row);
        end else if (int'(row) >= h - rad) begin
            dy = int'(row) - (h - rad - 1);
        end
        // grow the inset until the pixel center falls inside the circle
        while (dy != 0 && inset < rad) begin
            ex = 2 * (rad - inset) - 1;
            ey = 2 * dy - 1;
            if (ex * ex + ey * ey <= 4 * rad * rad) begin
                break;
            end
            inset++;
        end
        res.we = 1'b1;
        if (int'(row) >= h || int'(col) >= w) begin
            res.we = 1'b0;
        end else if (int'(col) < inset || int'(col) >= w - inset) begin
            res.we = 1'b0;
        end
        px = (int'(row) < h / 2) ? card_top_rgb : card_bot_rgb;
        if (!blank) begin
            px = blend565(px, digit_rgb, alpha);
        end
        if (shade != 8'd255) begin
            px = blend565('0, px, shade);
        end
        res.pixel = res.we ? px : '0;
        return res;
    endfunction

    // Driver: retire handshakes, predict accepted items, present the next step
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_cfg_valid  <= 1'b0;
            digit_rgb    = 16'hFFFF;
            card_top_rgb = '0;
            card_bot_rgb = '0;
            card_w       = 8'd64;
            card_h       = 8'd96;
            idle_left    = 0;
        end else begin
            if (start && !busy) begin
                due = shade_pixel(i_card_row, i_column, i_glyph_alpha, i_is_blank, i_shade);
                pixel_due_q.push_back(due);
                items_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIGIT_COLOR: digit_rgb    = i_cfg_data;
                    CFG_CARD_TOP:    card_top_rgb = i_cfg_data;
                    CFG_CARD_BOTTOM: card_bot_rgb = i_cfg_data;
                    CFG_CARD_WIDTH:  card_w       = i_cfg_data[7:0];
                    CFG_CARD_HEIGHT: card_h       = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            nxt_start = start && busy;
            nxt_cfg   = i_cfg_valid && !o_cfg_ready;
            if (!nxt_start && !nxt_cfg) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (step_q.size() > 0) begin
                    head = step_q[0];
                    case (head.kind)
                        STEP_PIXEL: begin
                            i_card_row    <= head.row;
                            i_column      <= head.col;
                            i_glyph_alpha <= head.alpha;
                            i_is_blank    <= head.blank;
                            i_shade       <= head.shade;
                            nxt_start     = 1'b1;
                            void'(step_q.pop_front());
                        end
                        STEP_GAP: begin
                            idle_left = head.gap_cycles - 1;
                            void'(step_q.pop_front());
                        end
                        STEP_REG_WRITE: begin
                            // write only with the pipeline empty
                            if (items_taken == results_seen) begin
                                i_cfg_index <= head.reg_idx;
                                i_cfg_data  <= head.reg_data;
                                nxt_cfg     = 1'b1;
                                void'(step_q.pop_front());
                            end
                        end
                        STEP_SETTLE: begin
                            if (items_taken == results_seen) begin
                                void'(step_q.pop_front());
                            end
                        end
                        default: ;
                    endcase
                end
            end
            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pixel_due_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual pixel %h we %b",
                         $time, o_pixel, o_write_enable);
                mismatches++;
            end else begin
                want = pixel_due_q.pop_front();
                if (o_pixel !== want.pixel) begin
                    $display("%0t: pixel mismatch: expected %h, actual %h",
                             $time, want.pixel, o_pixel);
                    mismatches++;
                end
                if (o_write_enable !== want.we) begin
                    $display("%0t: write_enable mismatch: expected %b, actual %b",
                             $time, want.we, o_write_enable);
                    mismatches++;
                end
            end
            results_seen <= results_seen + 1;
        end
    end

    task automatic add_pixel(input int row, input int col, input int alpha,
                             input int blank, input int shade);
        t_step s;
        s            = '{kind: STEP_PIXEL, default: '0};
        s.row        = 8'(row);
        s.col        = 8'(col);
        s.alpha      = 8'(alpha);
        s.blank      = 1'(blank);
        s.shade      = 8'(shade);
        step_q.push_back(s);
    endtask

    task automatic add_reg_write(input logic [2:0] idx, input logic [15:0] data);
        t_step s;
        s          = '{kind: STEP_REG_WRITE, default: '0};
        s.reg_idx  = idx;
        s.reg_data = data;
        step_q.push_back(s);
    endtask

    task automatic add_gap(input int cycles);
        t_step s;
        s            = '{kind: STEP_GAP, default: '0};
        s.gap_cycles = cycles;
        step_q.push_back(s);
    endtask

    task automatic add_settle();
        t_step s;
        s      = '{kind: STEP_SETTLE, default: '0};
        step_q.push_back(s);
    endtask

    // Stimulus, reset and end of run
    initial begin
        int         pw;
        int         ph;
        int         n_items;
        int         r;
        int         c;
        int         sel;
        int         a;
        int         shd;
        int         waited;
        logic       bursty;
        logic [15:0] c_digit;
        logic [15:0] c_top;
        logic [15:0] c_bot;

        // directed items on the reset card (64 x 96, split at row 48)
        add_pixel(0, 0, 255, 0, 255);
        add_pixel(0, 4, 255, 0, 255);
        add_pixel(1, 1, 128, 0, 255);
        add_pixel(3, 0, 0, 0, 255);
        add_pixel(3, 1, 255, 1, 255);
        add_pixel(4, 0, 255, 0, 0);
        add_pixel(47, 63, 255, 0, 254);
        add_pixel(48, 0, 255, 0, 1);
        add_pixel(92, 0, 200, 0, 255);
        add_pixel(95, 63, 255, 0, 255);
        add_pixel(95, 59, 255, 0, 255);
        add_pixel(91, 63, 100, 0, 255);
        add_pixel(96, 10, 255, 0, 255);
        add_pixel(10, 64, 255, 0, 255);
        add_pixel(254, 254, 255, 1, 0);
        add_pixel(200, 3, 77, 0, 200);
        add_pixel(20, 20, 1, 0, 128);
        add_pixel(20, 21, 254, 1, 255);
        add_pixel(50, 30, 0, 1, 0);
        add_pixel(30, 30, 170, 0, 85);

        pw = 64;
        ph = 96;
        for (int phase = 0; phase <= LAST_PHASE; phase++) begin
            // reprogram the card between phases
            if (phase > 0) begin
                c_digit = 16'($urandom);
                c_top   = 16'($urandom);
                c_bot   = 16'($urandom);
                pw      = $urandom_range(8, 255);
                ph      = $urandom_range(8, 255);
                case (phase)
                    1: begin
                        c_digit = 16'h0000; c_top = 16'hFFFF; c_bot = 16'h0000;
                        pw = 255; ph = 255;
                    end
                    2: begin
                        c_digit = 16'hFFFF; c_top = 16'h0000; c_bot = 16'hFFFF;
                        pw = 8; ph = 8;
                    end
                    3: begin pw = 0; ph = 1; end
                    4: begin pw = 1; ph = 0; end
                    5: begin pw = 5; ph = 3; end
                    6: begin pw = 255; ph = 8; end
                    default: ;
                endcase
                add_settle();
                add_reg_write(CFG_DIGIT_COLOR, c_digit);
                add_reg_write(CFG_CARD_TOP, c_top);
                add_reg_write(CFG_CARD_BOTTOM, c_bot);
                add_reg_write(CFG_CARD_WIDTH, {8'($urandom), 8'(pw)});
                add_reg_write(CFG_CARD_HEIGHT, {8'($urandom), 8'(ph)});
                // unused codes must leave the card alone
                add_reg_write(3'($urandom_range(int'(CFG_CARD_HEIGHT) + 1, int'(CFG_IDX_MAX))),
                              16'($urandom));
            end
            bursty  = (phase != LAST_PHASE) && (phase % 3 != 2);
            n_items = (phase == 0) ? 100 : (phase >= 3 && phase <= 5) ? 40 : 140;
            for (int k = 0; k < n_items; k++) begin
                // hold the sender until the pipeline drains
                if (phase == 1 && k == 60) begin
                    add_settle();
                end
                if (bursty && $urandom_range(0, 7) == 0) begin
                    add_gap($urandom_range(1, 10));
                end
                sel = $urandom_range(0, 9);
                if (sel <= 5) begin
                    r = (ph > 0) ? $urandom_range(0, ph - 1) : 0;
                    c = (pw > 0) ? $urandom_range(0, pw - 1) : 0;
                end else if (sel <= 7) begin
                    r = $urandom_range(0, 1) ? $urandom_range(0, 5)
                                             : ph - 1 - int'($urandom_range(0, 5));
                    c = $urandom_range(0, 1) ? $urandom_range(0, 5)
                                             : pw - 1 - int'($urandom_range(0, 5));
                end else begin
                    r = $urandom_range(0, 254);
                    c = $urandom_range(0, 254);
                end
                r = (r < 0) ? 0 : (r > 254) ? 254 : r;
                c = (c < 0) ? 0 : (c > 254) ? 254 : c;
                case ($urandom_range(0, 3))
                    0:       a = 0;
                    1:       a = 255;
                    default: a = $urandom_range(0, 255);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: shd = 255;
                    4:          shd = 0;
                    5:          shd = 254;
                    default:    shd = $urandom_range(0, 255);
                endcase
                add_pixel(r, c, a, ($urandom_range(0, 3) == 0), shd);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all steps issued, then all results back, then a short tail
        while (step_q.size() != 0 || start || i_cfg_valid) begin
            @(negedge i_clk);
        end
        waited = 0;
        while (pixel_due_q.size() != 0 && waited < 200) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (10) @(negedge i_clk);
        if (pixel_due_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pixel_due_q.size());
        end
        if (mismatches == 0 && pixel_due_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
